// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL. Both sample on the rising edge of clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_ni is high.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- hdl/sac_pkg.sv -----
package sac_pkg;

  localparam int unsigned AXIS_W = 12;
  localparam int unsigned CAL_W  = 36;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned NUM_AXES = 4;

  localparam logic [AXIS_W-1:0] FIELD_DEFAULT  = 12'hfff;
  localparam logic [AXIS_W-1:0] DEFAULT_CENTER = 12'd2048;
  localparam logic [AXIS_W-1:0] DEFAULT_OFFSET = 12'd1434;

  localparam logic [IDX_W-1:0] REG_LEFT_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEFT_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_RIGHT_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_KIND    = 3'd4;

  localparam logic [KIND_W-1:0] KIND_GENERIC    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LEFT_HALF  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RIGHT_HALF = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FULL_PAD   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RETRO_PAD  = 3'd4;

  typedef struct packed {
    logic neg;
    logic zero;
    logic sat;
  } flags_t;

endpackage

// ----- hdl/sac_div_step.sv -----
module sac_div_step #(
  parameter int unsigned PW = 23,
  parameter int unsigned QW = 11,
  parameter int unsigned HI = 10,
  parameter int unsigned NB = 2
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [PW-1:0]               rem_i,
  input  logic [QW-1:0]               quo_i,
  input  logic [sac_pkg::AXIS_W-1:0]  div_i,
  input  sac_pkg::flags_t             flags_i,
  output logic [PW-1:0]               rem_o,
  output logic [QW-1:0]               quo_o,
  output logic [sac_pkg::AXIS_W-1:0]  div_o,
  output sac_pkg::flags_t             flags_o
);

  logic [PW-1:0] rem_d;
  logic [QW-1:0] quo_d;
  logic [PW-1:0] trial;

  always_comb begin
    rem_d = rem_i;
    quo_d = quo_i;
    trial = '0;
    for (int unsigned j = 0; j < NB; j++) begin
      trial = PW'(div_i) << (HI - j);
      if (rem_d >= trial) begin
        rem_d = rem_d - trial;
        quo_d = quo_d | (QW'(1) << (HI - j));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o   <= rem_d;
      quo_o   <= quo_d;
      div_o   <= div_i;
      flags_o <= flags_i;
    end
  end

endmodule

// ----- hdl/sac_axis_lane.sv -----
module sac_axis_lane #(
  parameter int unsigned FULL_SCALE = 1140,
  parameter bit          NEGATE     = 1'b0,
  localparam int unsigned QW  = $clog2(FULL_SCALE + 1),
  localparam int unsigned ND  = (QW + 1) / 2,
  localparam int unsigned NST = ND + 2
) (
  input  logic                        clk_i,
  input  logic [NST-1:0]              en_i,
  input  logic [sac_pkg::AXIS_W-1:0]  raw_i,
  input  logic [sac_pkg::CAL_W-1:0]   cal_i,
  output logic [sac_pkg::AXIS_W-1:0]  res_o
);

  localparam int unsigned AW = sac_pkg::AXIS_W;
  localparam int unsigned PW = AW + QW;
  localparam int unsigned RW = (QW + 1 > AW) ? QW + 1 : AW;

  logic [AW-1:0]   center, up_off, lo_off;
  logic            above;
  logic [AW-1:0]   dist_d, off_d;
  sac_pkg::flags_t flags_d;

  logic [AW-1:0]   dist_q, off1_q;
  sac_pkg::flags_t flags1_q;
  logic [PW-1:0]   prod_q;
  logic [AW-1:0]   off2_q;
  sac_pkg::flags_t flags2_q;

  logic [PW-1:0]   rem_s   [ND+1];
  logic [QW-1:0]   quo_s   [ND+1];
  logic [AW-1:0]   div_s   [ND+1];
  sac_pkg::flags_t flags_s [ND+1];

  logic [QW-1:0]        mag;
  logic signed [RW-1:0] val;

  always_comb begin
    center = (cal_i[11:0] == sac_pkg::FIELD_DEFAULT) ? sac_pkg::DEFAULT_CENTER : cal_i[11:0];
    up_off = (cal_i[23:12] == sac_pkg::FIELD_DEFAULT) ? sac_pkg::DEFAULT_OFFSET : cal_i[23:12];
    lo_off = (cal_i[35:24] == sac_pkg::FIELD_DEFAULT) ? sac_pkg::DEFAULT_OFFSET : cal_i[35:24];
    above  = raw_i > center;
    dist_d = above ? (raw_i - center) : (center - raw_i);
    off_d  = above ? up_off : lo_off;
    flags_d.neg  = !above;
    flags_d.zero = (dist_d == '0);
    flags_d.sat  = (dist_d >= off_d);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      dist_q   <= dist_d;
      off1_q   <= off_d;
      flags1_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      prod_q   <= PW'(dist_q) * PW'(FULL_SCALE);
      off2_q   <= off1_q;
      flags2_q <= flags1_q;
    end
  end

  assign rem_s[0]   = prod_q;
  assign quo_s[0]   = '0;
  assign div_s[0]   = off2_q;
  assign flags_s[0] = flags2_q;

  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int unsigned HI = QW - 1 - 2 * k;
    sac_div_step #(
      .PW (PW),
      .QW (QW),
      .HI (HI),
      .NB ((HI >= 1) ? 2 : 1)
    ) u_step (
      .clk_i   (clk_i),
      .en_i    (en_i[k+2]),
      .rem_i   (rem_s[k]),
      .quo_i   (quo_s[k]),
      .div_i   (div_s[k]),
      .flags_i (flags_s[k]),
      .rem_o   (rem_s[k+1]),
      .quo_o   (quo_s[k+1]),
      .div_o   (div_s[k+1]),
      .flags_o (flags_s[k+1])
    );
  end

  always_comb begin
    priority if (flags_s[ND].zero) begin
      mag = '0;
    end else if (flags_s[ND].sat) begin
      mag = QW'(FULL_SCALE);
    end else begin
      mag = quo_s[ND];
    end
    val   = (flags_s[ND].neg ^ NEGATE) ? -$signed(RW'(mag)) : $signed(RW'(mag));
    res_o = val[AW-1:0];
  end

endmodule

// ----- hdl/stick_axis_calibrator_top.sv -----
// A report passes through the distance register, the product register, one register per
// divider stage and the output register; the depth follows the bit width of FULL_SCALE.
// Throughput: one report per cycle while m_axis_tready does not stall the output; the
// restoring divider resolves up to two quotient bits per stage and sets the depth.
// Reset clears the stage valid bits, sets every calibration field to its default value
// and the device kind to generic.
`include "assert_macros.svh"

module stick_axis_calibrator_top #(
  parameter int unsigned FULL_SCALE = 1140
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sac_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [sac_pkg::CAL_W-1:0]    cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // raw_left_x, raw_left_y, raw_right_x, raw_right_y
  input  logic [47:0]                  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // out_left_x, out_left_y, out_right_x, out_right_y
  output logic [47:0]                  m_axis_tdata,
  // left_present, right_present
  output logic [1:0]                   m_axis_tuser
);

  localparam int unsigned AW  = sac_pkg::AXIS_W;
  localparam int unsigned QW  = $clog2(FULL_SCALE + 1);
  localparam int unsigned ND  = (QW + 1) / 2;
  localparam int unsigned NST = ND + 2;
  localparam int unsigned L   = NST + 1;

  logic [sac_pkg::CAL_W-1:0]  cal_q [sac_pkg::NUM_AXES];
  logic [sac_pkg::KIND_W-1:0] kind_q;

  logic [L-1:0] v_q, v_d;
  logic [L:0]   rdy;

  logic [AW-1:0] res [sac_pkg::NUM_AXES];
  logic          left_present, right_present;
  logic [47:0]   data_q;
  logic [1:0]    user_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sac_pkg::NUM_AXES; i++) begin
        cal_q[i] <= '1;
      end
      kind_q <= sac_pkg::KIND_GENERIC;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sac_pkg::REG_LEFT_X:  cal_q[0] <= cfg_data_i;
        sac_pkg::REG_LEFT_Y:  cal_q[1] <= cfg_data_i;
        sac_pkg::REG_RIGHT_X: cal_q[2] <= cfg_data_i;
        sac_pkg::REG_RIGHT_Y: cal_q[3] <= cfg_data_i;
        sac_pkg::REG_KIND:    kind_q   <= cfg_data_i[sac_pkg::KIND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rdy[L] = m_axis_tready;
    for (int k = L - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    for (int k = 0; k < L; k++) begin
      if (!rdy[k]) begin
        v_d[k] = v_q[k];
      end else if (k == 0) begin
        v_d[k] = s_axis_tvalid;
      end else begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[0];

  for (genvar i = 0; i < sac_pkg::NUM_AXES; i++) begin : g_lane
    sac_axis_lane #(
      .FULL_SCALE (FULL_SCALE),
      .NEGATE     ((i == 1) || (i == 3))
    ) u_lane (
      .clk_i (clk_i),
      .en_i  (rdy[NST-1:0]),
      .raw_i (s_axis_tdata[i*AW +: AW]),
      .cal_i (cal_q[i]),
      .res_o (res[i])
    );
  end

  assign left_present  = (kind_q != sac_pkg::KIND_RIGHT_HALF);
  assign right_present = (kind_q != sac_pkg::KIND_LEFT_HALF) &&
                         (kind_q != sac_pkg::KIND_RETRO_PAD);

  always_ff @(posedge clk_i) begin
    if (rdy[L-1]) begin
      data_q[11:0]  <= left_present  ? res[0] : '0;
      data_q[23:12] <= left_present  ? res[1] : '0;
      data_q[35:24] <= right_present ? res[2] : '0;
      data_q[47:36] <= right_present ? res[3] : '0;
      user_q        <= {right_present, left_present};
    end
  end

  assign m_axis_tvalid = v_q[L-1];
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;

  `ASSERT_RST(a_accept_fills_stage, s_axis_tvalid && s_axis_tready |=> v_q[0], "accepted report lost at the first stage")
  `ASSERT_RST(a_ready_when_out_free, !v_q[L-1] |-> s_axis_tready, "input stalled with a free output register")
  `ASSERT_RST(a_left_absent_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:0] == 24'd0, "missing left stick gives a nonzero value")
  `ASSERT_RST(a_right_absent_zero, m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[47:24] == 24'd0, "missing right stick gives a nonzero value")
  `ASSERT_ALL(a_no_valid_in_reset, !rst_ni |-> !m_axis_tvalid, "result shown while in reset")

endmodule

// ----- tb/sv/stick_axis_calibrator_checker.sv -----
module stick_axis_calibrator_checker #(
  parameter int unsigned FULL_SCALE = 1140
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [sac_pkg::IDX_W-1:0]   cfg_index_i,
  input  logic [sac_pkg::CAL_W-1:0]   cfg_data_i,
  input  logic                        s_axis_tvalid,
  input  logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,
  input  logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  input  logic [47:0]                 m_axis_tdata,
  input  logic [1:0]                  m_axis_tuser,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          reports_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AXIS_W = sac_pkg::AXIS_W;
  localparam int unsigned CAL_W  = sac_pkg::CAL_W;
  localparam int unsigned KIND_W = sac_pkg::KIND_W;

  typedef struct packed {
    logic [AXIS_W-1:0] left_x;
    logic [AXIS_W-1:0] left_y;
    logic [AXIS_W-1:0] right_x;
    logic [AXIS_W-1:0] right_y;
    logic              left_present;
    logic              right_present;
  } stick_report_t;

  logic [CAL_W-1:0]  axis_cal [sac_pkg::NUM_AXES];
  logic [KIND_W-1:0] device_kind;
  stick_report_t     calibrated_q [$];
  int                fail_count;
  int                accepted_total;

  function automatic logic [AXIS_W-1:0] scale_axis(input logic [CAL_W-1:0] cal,
                                                   input logic [AXIS_W-1:0] raw);
    int centre;
    int upper;
    int lower;
    int sample;
    int span;
    int q;
    centre = (cal[11:0] == sac_pkg::FIELD_DEFAULT) ? int'(sac_pkg::DEFAULT_CENTER) :
                                                     int'(cal[11:0]);
    upper  = (cal[23:12] == sac_pkg::FIELD_DEFAULT) ? int'(sac_pkg::DEFAULT_OFFSET) :
                                                      int'(cal[23:12]);
    lower  = (cal[35:24] == sac_pkg::FIELD_DEFAULT) ? int'(sac_pkg::DEFAULT_OFFSET) :
                                                      int'(cal[35:24]);
    sample = int'(raw);
    if (sample > centre) begin
      span = sample - centre;
      q = (upper == 0) ? int'(FULL_SCALE) : (span * int'(FULL_SCALE)) / upper;
    end else begin
      span = centre - sample;
      if (span == 0) begin
        q = 0;
      end else if (lower == 0) begin
        q = -int'(FULL_SCALE);
      end else begin
        q = -((span * int'(FULL_SCALE)) / lower);
      end
    end
    if (q > int'(FULL_SCALE)) begin
      q = int'(FULL_SCALE);
    end
    if (q < -int'(FULL_SCALE)) begin
      q = -int'(FULL_SCALE);
    end
    return q[AXIS_W-1:0];
  endfunction

  function automatic stick_report_t calibrate_report(input logic [47:0] raw);
    stick_report_t r;
    logic          has_left;
    logic          has_right;
    has_left  = (device_kind != sac_pkg::KIND_RIGHT_HALF);
    has_right = (device_kind != sac_pkg::KIND_LEFT_HALF) &&
                (device_kind != sac_pkg::KIND_RETRO_PAD);
    r.left_x  = has_left ? scale_axis(axis_cal[0], raw[11:0]) : '0;
    r.left_y  = has_left ? -scale_axis(axis_cal[1], raw[23:12]) : '0;
    r.right_x = has_right ? scale_axis(axis_cal[2], raw[35:24]) : '0;
    r.right_y = has_right ? -scale_axis(axis_cal[3], raw[47:36]) : '0;
    r.left_present  = has_left;
    r.right_present = has_right;
    return r;
  endfunction

  function automatic int check_field(input string name, input logic signed [AXIS_W-1:0] want,
                                     input logic signed [AXIS_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stick_report_t want;
    if (!rst_ni) begin
      foreach (axis_cal[i]) begin
        axis_cal[i] = '1;
      end
      device_kind = sac_pkg::KIND_GENERIC;
      calibrated_q.delete();
      fail_count = 0;
      accepted_total = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          sac_pkg::REG_LEFT_X, sac_pkg::REG_LEFT_Y,
          sac_pkg::REG_RIGHT_X, sac_pkg::REG_RIGHT_Y: begin
            axis_cal[cfg_index_i[1:0]] = cfg_data_i;
          end
          sac_pkg::REG_KIND: begin
            device_kind = cfg_data_i[KIND_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        calibrated_q.push_back(calibrate_report(s_axis_tdata));
        accepted_total++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (calibrated_q.size() == 0) begin
          $error("result transfer arrived with no report outstanding");
          fail_count++;
        end else begin
          want = calibrated_q.pop_front();
          fail_count += check_field("out_left_x", want.left_x, m_axis_tdata[11:0]);
          fail_count += check_field("out_left_y", want.left_y, m_axis_tdata[23:12]);
          fail_count += check_field("out_right_x", want.right_x, m_axis_tdata[35:24]);
          fail_count += check_field("out_right_y", want.right_y, m_axis_tdata[47:36]);
          fail_count += check_field("left_present", AXIS_W'(want.left_present),
                                    AXIS_W'(m_axis_tuser[0]));
          fail_count += check_field("right_present", AXIS_W'(want.right_present),
                                    AXIS_W'(m_axis_tuser[1]));
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= calibrated_q.size();
    reports_o    <= accepted_total;
  end

endmodule

// ----- tb/sv/stick_axis_calibrator_top_test.sv -----
module stick_axis_calibrator_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned AXIS_W = sac_pkg::AXIS_W;
  localparam int unsigned CAL_W  = sac_pkg::CAL_W;
  localparam int unsigned IDX_W  = sac_pkg::IDX_W;
  localparam int unsigned KIND_W = sac_pkg::KIND_W;

  localparam logic [AXIS_W-1:0] FIELD_DEFAULT  = sac_pkg::FIELD_DEFAULT;
  localparam logic [AXIS_W-1:0] DEFAULT_CENTER = sac_pkg::DEFAULT_CENTER;
  localparam logic [AXIS_W-1:0] DEFAULT_OFFSET = sac_pkg::DEFAULT_OFFSET;

  localparam int unsigned FULL_SCALE     = 1140;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          PHASES         = 19;
  localparam int          PHASE_REPORTS  = 100;
  localparam int          PRESSURE_PHASE = 5;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [IDX_W-1:0]   cfg_index_i;
  logic [CAL_W-1:0]   cfg_data_i;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [47:0]        s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [47:0]        m_axis_tdata;
  logic [1:0]         m_axis_tuser;

  int fail_count;
  int pending;
  int reports;
  int settings;
  bit hold_req;

  stick_axis_calibrator_top #(
    .FULL_SCALE(FULL_SCALE)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  stick_axis_calibrator_checker #(
    .FULL_SCALE(FULL_SCALE)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .reports_o     (reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic [CAL_W-1:0] rand_word();
    return CAL_W'({$urandom, $urandom});
  endfunction

  function automatic logic [CAL_W-1:0] pack_cal(input logic [AXIS_W-1:0] centre,
                                                input logic [AXIS_W-1:0] upper,
                                                input logic [AXIS_W-1:0] lower);
    return {lower, upper, centre};
  endfunction

  function automatic logic [AXIS_W-1:0] pick_cal_field();
    case ($urandom_range(0, 7))
      0, 1: return FIELD_DEFAULT;
      2: return '0;
      3: return AXIS_W'($urandom_range(1, 3));
      4: return AXIS_W'(FIELD_DEFAULT - 1);
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_kind(input int kind);
    write_reg(sac_pkg::REG_KIND, CAL_W'({rand_word() >> KIND_W, KIND_W'(kind)}));
  endtask

  task automatic send_report(input logic [AXIS_W-1:0] lx, input logic [AXIS_W-1:0] ly,
                             input logic [AXIS_W-1:0] rx, input logic [AXIS_W-1:0] ry,
                             input int gap);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {ry, rx, ly, lx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Registers may only change once every outstanding report has come back.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_all_cal(input logic [CAL_W-1:0] cal, input int kind);
    settle();
    write_reg(sac_pkg::REG_LEFT_X, cal);
    write_reg(sac_pkg::REG_LEFT_Y, cal);
    write_reg(sac_pkg::REG_RIGHT_X, cal);
    write_reg(sac_pkg::REG_RIGHT_Y, cal);
    write_kind(kind);
    settings++;
  endtask

  task automatic configure_random();
    settle();
    write_reg(sac_pkg::REG_LEFT_X,
              pack_cal(pick_cal_field(), pick_cal_field(), pick_cal_field()));
    write_reg(sac_pkg::REG_LEFT_Y,
              pack_cal(pick_cal_field(), pick_cal_field(), pick_cal_field()));
    write_reg(sac_pkg::REG_RIGHT_X,
              pack_cal(pick_cal_field(), pick_cal_field(), pick_cal_field()));
    write_reg(sac_pkg::REG_RIGHT_Y,
              pack_cal(pick_cal_field(), pick_cal_field(), pick_cal_field()));
    write_kind($urandom_range(0, (1 << KIND_W) - 1));
    if ($urandom_range(0, 3) == 0) begin
      write_reg(IDX_W'($urandom_range(int'(sac_pkg::REG_KIND) + 1, (1 << IDX_W) - 1)),
                rand_word());
    end
    settings++;
  endtask

  function automatic logic [AXIS_W-1:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return AXIS_W'(DEFAULT_CENTER + AXIS_W'($urandom_range(0, 6)) - 3);
      default: return AXIS_W'($urandom);
    endcase
  endfunction

  // Receiver: bursts of steady or choppy acceptance, plus one long hold when asked.
  initial begin
    int stall_left;
    int burst_left;
    bit choppy;
    bit held;
    stall_left = 0;
    burst_left = 0;
    choppy = 1'b0;
    held = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !held) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        held = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(10, 150);
          choppy = ($urandom_range(0, 2) != 0);
        end
        burst_left--;
        if (choppy && $urandom_range(0, 3) == 0) begin
          stall_left = gap_len() - 1;
          m_axis_tready = 1'b0;
        end else begin
          m_axis_tready = 1'b1;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("stick_axis_calibrator_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    bit gappy;
    int idx;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    hold_req      = 1'b0;
    settings      = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset calibration: defaults, exact full-scale points and truncation near the centre.
    send_report('0, '0, '0, '0, 0);
    send_report('1, '1, '1, '1, 0);
    send_report(DEFAULT_CENTER, DEFAULT_CENTER, DEFAULT_CENTER, DEFAULT_CENTER, 0);
    send_report(AXIS_W'(DEFAULT_CENTER + 1), AXIS_W'(DEFAULT_CENTER - 1),
                AXIS_W'(DEFAULT_CENTER + 1), AXIS_W'(DEFAULT_CENTER - 1), 1);
    send_report(DEFAULT_CENTER + DEFAULT_OFFSET, DEFAULT_CENTER - DEFAULT_OFFSET,
                DEFAULT_CENTER - DEFAULT_OFFSET, DEFAULT_CENTER + DEFAULT_OFFSET, 0);

    // Writes to indexes past the last register must change nothing.
    settle();
    for (idx = int'(sac_pkg::REG_KIND) + 1; idx < (1 << IDX_W); idx++) begin
      write_reg(IDX_W'(idx), '0);
    end
    send_report('1, '0, '1, '0, 0);

    // Zero offsets: saturation on any nonzero distance; then extreme centres and offsets.
    write_all_cal('0, int'(sac_pkg::KIND_FULL_PAD));
    send_report('0, '0, '0, '0, 0);
    send_report(AXIS_W'(1), AXIS_W'(1), '1, '1, 0);
    write_all_cal(pack_cal(AXIS_W'(FIELD_DEFAULT - 1), '0, '0), int'(sac_pkg::KIND_GENERIC));
    send_report('1, '0, AXIS_W'(FIELD_DEFAULT - 1), '1, 0);
    send_report('0, '1, '0, AXIS_W'(FIELD_DEFAULT - 1), 2);
    write_all_cal(pack_cal(DEFAULT_CENTER, AXIS_W'(1), AXIS_W'(FIELD_DEFAULT - 1)),
                  int'(sac_pkg::KIND_GENERIC));
    send_report(AXIS_W'(DEFAULT_CENTER + 1), '0, '1, AXIS_W'(DEFAULT_CENTER - 1), 0);

    // Every device kind, including the unused codes, with all sticks away from centre.
    for (idx = 0; idx < (1 << KIND_W); idx++) begin
      settle();
      write_kind(idx);
      settings++;
      send_report('1, '0, '0, '1, 0);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      configure_random();
      gappy = (phase != PRESSURE_PHASE) && ($urandom_range(0, 2) != 0);
      if (phase == PRESSURE_PHASE) begin
        hold_req = 1'b1;
      end
      repeat (PHASE_REPORTS) begin
        send_report(pick_raw(), pick_raw(), pick_raw(), pick_raw(),
                    (gappy && $urandom_range(0, 2) == 0) ? gap_len() : 0);
      end
    end

    settle();
    $display("Run covered %0d reports over %0d register settings, every device kind,", reports,
             settings);
    $display("default, zero and extreme calibration fields, and one long output stall.");
    if (fail_count == 0 && pending == 0) begin
      $display("stick_axis_calibrator_top verification clean");
    end else begin
      $display("stick_axis_calibrator_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/sac_pkg.sv
hdl/sac_div_step.sv
hdl/sac_axis_lane.sv
hdl/stick_axis_calibrator_top.sv
tb/sv/stick_axis_calibrator_checker.sv
tb/sv/stick_axis_calibrator_top_test.sv
